FILE: rtl/bounded_list_store_engine_core_macros.svh
// assertion macros for the bounded list store checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef BOUNDED_LIST_STORE_ENGINE_CORE_MACROS_SVH
`define BOUNDED_LIST_STORE_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define BLS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BLS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bls_pkg.sv
// shared types and constants of the bounded list store engine
// no dependencies
`default_nettype none
package bls_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        OP_APPEND  = 3'd0,
        OP_FIND    = 3'd1,
        OP_REM1    = 3'd2,
        OP_REMALL  = 3'd3,
        OP_SORT    = 3'd4,
        OP_READ    = 3'd5,
        OP_CLEAR   = 3'd6,
        OP_STATUS  = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NF    = 2'd1,
        ST_FULL  = 2'd2,
        ST_OOR   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_START,
        CMD_RD_SCAN,
        CMD_SCAN,
        CMD_RD_KEY,
        CMD_KEY,
        CMD_RD_J,
        CMD_JSTEP,
        CMD_PLACE,
        CMD_RD_POS,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    cnt_zero;
        logic    match;
        logic    scan_last;
        logic    sort_more;
        logic    gt;
        logic    j_one;
        logic    key_last;
        logic    out_free;
    } sts_t;

endpackage
`default_nettype wire

FILE: rtl/bls_datapath.sv
// datapath: element memory, pointers, count, sorted flag and result register
// depends on bls_pkg
`default_nettype none
module bls_datapath
    import bls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output sts_t                    sts,
    input  wire logic [2:0]         opcode,
    input  wire logic signed [31:0] value,
    input  wire logic [5:0]         position,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              status,
    output logic [5:0]              found_index,
    output logic signed [31:0]      read_value,
    output logic [6:0]              removed_count,
    output logic [6:0]              item_count,
    output logic                    sorted_flag
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > 6) ? CW : 6) + 1;

    logic signed [WIDTH-1:0] mem [DEPTH];

    opcode_t                 op_reg;
    logic signed [WIDTH-1:0] val_reg, key_reg, rdata_reg;
    logic [5:0]              pos_reg;
    logic [CW-1:0]           cnt_reg, rp_reg, wp_reg, ip_reg, jp_reg, fidx_reg;
    logic                    hit_reg, ord_reg;

    logic                    ov_reg;
    logic [1:0]              st_reg;
    logic [5:0]              fi_reg;
    logic signed [31:0]      rv_reg;
    logic [6:0]              rc_reg, ic_reg;
    logic                    sf_reg;

    logic                    rd_en, wr_en, match, drop, in_range, full;
    logic [AW-1:0]           raddr, waddr;
    logic signed [WIDTH-1:0] wdata;
    logic [CW:0]             rp_inc, ip_inc;

    assign match    = (rdata_reg == val_reg);
    assign drop     = match && ((op_reg == OP_REMALL) || !hit_reg);
    assign rp_inc   = {1'b0, rp_reg} + 1'b1;
    assign ip_inc   = {1'b0, ip_reg} + 1'b1;
    assign in_range = XW'(pos_reg) < XW'(cnt_reg);
    assign full     = (cnt_reg == CW'(DEPTH));

    always_comb
    begin
        sts.op        = op_reg;
        sts.cnt_zero  = (cnt_reg == '0);
        sts.match     = match;
        sts.scan_last = (rp_inc >= {1'b0, cnt_reg});
        sts.sort_more = (ip_reg < cnt_reg);
        sts.gt        = (rdata_reg > key_reg);
        sts.j_one     = (jp_reg == CW'(1));
        sts.key_last  = (ip_inc >= {1'b0, cnt_reg});
        sts.out_free  = !ov_reg || out_ready;
    end

    // memory port control
    always_comb
    begin
        rd_en = 1'b0;
        wr_en = 1'b0;
        raddr = AW'(rp_reg);
        waddr = AW'(wp_reg);
        wdata = rdata_reg;
        case (cmd)
            CMD_RD_SCAN: rd_en = 1'b1;
            CMD_RD_KEY:
            begin
                rd_en = 1'b1;
                raddr = AW'(ip_reg);
            end
            CMD_RD_J:
            begin
                rd_en = 1'b1;
                raddr = AW'(jp_reg - 1'b1);
            end
            CMD_RD_POS:
            begin
                rd_en = 1'b1;
                raddr = AW'(pos_reg);
            end
            CMD_SCAN:
            begin
                wr_en = (op_reg != OP_FIND) && !drop;
            end
            CMD_JSTEP:
            begin
                wr_en = 1'b1;
                waddr = AW'(jp_reg);
                wdata = sts.gt ? rdata_reg : key_reg;
            end
            CMD_PLACE:
            begin
                wr_en = 1'b1;
                waddr = AW'(jp_reg);
                wdata = key_reg;
            end
            CMD_FINISH:
            begin
                wr_en = (op_reg == OP_APPEND) && !full;
                waddr = AW'(cnt_reg);
                wdata = val_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[waddr] <= wdata;
        if (rd_en)
            rdata_reg <= mem[raddr];
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_START:
            begin
                op_reg   <= opcode_t'(opcode);
                val_reg  <= WIDTH'(value);
                pos_reg  <= position;
                rp_reg   <= '0;
                wp_reg   <= '0;
                ip_reg   <= CW'(1);
                fidx_reg <= '0;
                hit_reg  <= 1'b0;
            end
            CMD_SCAN:
            begin
                rp_reg <= CW'(rp_inc);
                if (op_reg == OP_FIND)
                begin
                    if (match && !hit_reg)
                    begin
                        hit_reg  <= 1'b1;
                        fidx_reg <= rp_reg;
                    end
                end
                else if (drop)
                begin
                    hit_reg <= 1'b1;
                    if (!hit_reg)
                        fidx_reg <= rp_reg;
                end
                else
                    wp_reg <= wp_reg + 1'b1;
            end
            CMD_KEY:
            begin
                key_reg <= rdata_reg;
                jp_reg  <= ip_reg;
            end
            CMD_JSTEP:
            begin
                if (sts.gt)
                    jp_reg <= jp_reg - 1'b1;
                else
                    ip_reg <= CW'(ip_inc);
            end
            CMD_PLACE: ip_reg <= CW'(ip_inc);
            default: ;
        endcase
    end

    // list state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ord_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            if (cmd == CMD_FINISH)
            begin
                ov_reg <= 1'b1;
                st_reg <= ST_OK;
                fi_reg <= '0;
                rv_reg <= '0;
                rc_reg <= '0;
                ic_reg <= 7'(cnt_reg);
                sf_reg <= ord_reg;
                case (op_reg)
                    OP_APPEND:
                    begin
                        if (full)
                            st_reg <= ST_FULL;
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                            ic_reg  <= 7'(cnt_reg + 1'b1);
                        end
                    end
                    OP_FIND:
                    begin
                        if (hit_reg)
                            fi_reg <= 6'(fidx_reg);
                        else
                            st_reg <= ST_NF;
                    end
                    OP_REM1, OP_REMALL:
                    begin
                        if (hit_reg)
                        begin
                            fi_reg  <= 6'(fidx_reg);
                            rc_reg  <= 7'(cnt_reg - wp_reg);
                            cnt_reg <= wp_reg;
                            ic_reg  <= 7'(wp_reg);
                        end
                        else
                            st_reg <= ST_NF;
                    end
                    OP_SORT:
                    begin
                        if (cnt_reg > CW'(1))
                        begin
                            ord_reg <= 1'b1;
                            sf_reg  <= 1'b1;
                        end
                    end
                    OP_READ:
                    begin
                        if (in_range)
                            rv_reg <= 32'(rdata_reg);
                        else
                            st_reg <= ST_OOR;
                    end
                    OP_CLEAR:
                    begin
                        cnt_reg <= '0;
                        ord_reg <= 1'b0;
                        ic_reg  <= '0;
                        sf_reg  <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign out_valid     = ov_reg;
    assign status        = st_reg;
    assign found_index   = fi_reg;
    assign read_value    = rv_reg;
    assign removed_count = rc_reg;
    assign item_count    = ic_reg;
    assign sorted_flag   = sf_reg;

endmodule
`default_nettype wire

FILE: rtl/bls_ctrl.sv
// controller state machine sequencing scan, sort and read walks
// depends on bls_pkg
`default_nettype none
module bls_ctrl
    import bls_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DISP  = 11'b00000000010,
        S_SRD   = 11'b00000000100,
        S_SCMP  = 11'b00000001000,
        S_KRD   = 11'b00000010000,
        S_KLD   = 11'b00000100000,
        S_JRD   = 11'b00001000000,
        S_JCMP  = 11'b00010000000,
        S_PLACE = 11'b00100000000,
        S_PRD   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_START;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.op)
                    OP_FIND, OP_REM1, OP_REMALL:
                        state_next = sts.cnt_zero ? S_DONE : S_SRD;
                    OP_SORT:  state_next = sts.sort_more ? S_KRD : S_DONE;
                    OP_READ:  state_next = S_PRD;
                    default:  state_next = S_DONE;
                endcase
            end
            S_SRD:
            begin
                cmd        = CMD_RD_SCAN;
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                cmd = CMD_SCAN;
                if ((sts.op == OP_FIND && sts.match) || sts.scan_last)
                    state_next = S_DONE;
                else
                    state_next = S_SRD;
            end
            S_KRD:
            begin
                cmd        = CMD_RD_KEY;
                state_next = S_KLD;
            end
            S_KLD:
            begin
                cmd        = CMD_KEY;
                state_next = S_JRD;
            end
            S_JRD:
            begin
                cmd        = CMD_RD_J;
                state_next = S_JCMP;
            end
            S_JCMP:
            begin
                cmd = CMD_JSTEP;
                if (sts.gt)
                    state_next = sts.j_one ? S_PLACE : S_JRD;
                else
                    state_next = sts.key_last ? S_DONE : S_KRD;
            end
            S_PLACE:
            begin
                cmd        = CMD_PLACE;
                state_next = sts.key_last ? S_DONE : S_KRD;
            end
            S_PRD:
            begin
                cmd        = CMD_RD_POS;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd        = CMD_FINISH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

FILE: rtl/bounded_list_store_engine_core.sv
// append, clear and status finish without a walk and read fetches one word; find and remove
// walk the words (one memory read then one compare per word); sort walks each key and shifts
// larger words up one place at a time, so it is slowest on reversed data
// one command at a time: the single-port element memory sets the pace of every walk
// reset (rst_n, asynchronous, active low) empties the list and clears the sorted flag;
// the element memory keeps its contents and needs no clearing pass
`default_nettype none
module bounded_list_store_engine_core
    import bls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         opcode,
    input  wire logic signed [31:0] value,
    input  wire logic [5:0]         position,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              status,
    output logic [5:0]              found_index,
    output logic signed [31:0]      read_value,
    output logic [6:0]              removed_count,
    output logic [6:0]              item_count,
    output logic                    sorted_flag
);

    // command from controller, flags back from datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: walks the memory word by word for find, remove and sort, and reads one word for read
    bls_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // memory, pointers and the result word register
    bls_datapath #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .opcode        (opcode),
        .value         (value),
        .position      (position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .found_index   (found_index),
        .read_value    (read_value),
        .removed_count (removed_count),
        .item_count    (item_count),
        .sorted_flag   (sorted_flag)
    );

endmodule
`default_nettype wire

FILE: rtl/bls_chk.sv
// port-level checker for the bounded list store engine, bound to the top level
// depends on bls_pkg and the assertion macro header
`default_nettype none
`include "bounded_list_store_engine_core_macros.svh"
module bls_chk
    import bls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  status,
    input wire logic [31:0] read_value,
    input wire logic [6:0]  removed_count,
    input wire logic [6:0]  item_count
);

    `BLS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")
    `BLS_ASSERT_IMP(a_cnt_max, out_valid, 32'(item_count) <= DEPTH, "count above depth")
    `BLS_ASSERT_IMP(a_full, out_valid && status == ST_FULL, 32'(item_count) == DEPTH, "full")
    `BLS_ASSERT_IMP(a_rm_ok, out_valid && removed_count != '0, status == ST_OK, "removal with bad status")
    `BLS_ASSERT_IMP(a_rd_ok, out_valid && read_value != '0, status == ST_OK, "read data with bad status")

endmodule

bind bounded_list_store_engine_core bls_chk #(.DEPTH(DEPTH)) u_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .read_value    (read_value),
    .removed_count (removed_count),
    .item_count    (item_count)
);
`default_nettype wire
